[design/nir_pkg.sv]
package nir_pkg;

    localparam int ID_W   = 16;
    localparam int ADDR_W = 16;
    localparam int TLEN_W = 16;
    localparam int PLEN_W = 6;
    localparam int TMO_W  = 12;
    localparam int EXP_W  = 17;

    localparam logic [PLEN_W-1:0] MAX_PAYLOAD = 6'd32;
    localparam logic [TMO_W-1:0]  TMO_RESET   = 12'd16;
    localparam logic              REQ_TICK    = 1'b1;

    typedef enum logic {
        PH_WAIT = 1'b0,
        PH_RECV = 1'b1
    } phase_t;

    typedef struct packed {
        logic              is_tick;
        logic [ID_W-1:0]   id;
        logic [ADDR_W-1:0] addr;
        logic              addr_zero;
        logic [TLEN_W-1:0] tlen;
        logic [PLEN_W-1:0] plen;
    } item_t;

    typedef struct packed {
        logic              write_en;
        logic [ADDR_W-1:0] write_addr;
        logic [PLEN_W-1:0] write_len;
        logic              nack_en;
        logic [ADDR_W-1:0] nack_addr;
        logic              image_done;
    } res_t;

endpackage

[design/nack_image_receiver.sv]
// channel | dir | handshake          | payload
// input   | in  | push / full        | req_type pkt_id pkt_addr pkt_total_len pkt_payload_len
// result  | out | pop / empty        | write_en write_addr write_len nack_en nack_addr image_done
// config  | in  | cfg_valid / ready  | cfg_data (retry timeout)
//
// One word per cycle sustained while the result queue has room; a word's result
// enters the result queue at the edge at which the back stage pops it from the
// front queue and updates the receiver state from it.
// Reset clears both queues and the receiver state; the timeout resets to 16.
// A stalled result side fills the result queue, then the front queue, then
// raises full. cfg_ready is always high.
module nack_image_receiver #(
    parameter int FRONT_DEPTH = 2,
    parameter int OUT_DEPTH   = 2
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic                       req_type,
    input  logic [nir_pkg::ID_W-1:0]   pkt_id,
    input  logic [nir_pkg::ADDR_W-1:0] pkt_addr,
    input  logic [nir_pkg::TLEN_W-1:0] pkt_total_len,
    input  logic [nir_pkg::PLEN_W-1:0] pkt_payload_len,
    output logic                       empty,
    input  logic                       pop,
    output logic                       write_en,
    output logic [nir_pkg::ADDR_W-1:0] write_addr,
    output logic [nir_pkg::PLEN_W-1:0] write_len,
    output logic                       nack_en,
    output logic [nir_pkg::ADDR_W-1:0] nack_addr,
    output logic                       image_done,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [nir_pkg::TMO_W-1:0]  cfg_data
);

    nir_pkg::item_t front_item;
    nir_pkg::item_t back_item;
    nir_pkg::res_t  back_res;
    nir_pkg::res_t  out_res;
    logic           fq_push;
    logic           fq_full;
    logic           fq_empty;
    logic           fq_pop;
    logic           oq_push;
    logic           oq_full;

    assign cfg_ready = 1'b1;

    nir_front u_front (
        .push            (push),
        .full            (full),
        .req_type        (req_type),
        .pkt_id          (pkt_id),
        .pkt_addr        (pkt_addr),
        .pkt_total_len   (pkt_total_len),
        .pkt_payload_len (pkt_payload_len),
        .q_push          (fq_push),
        .q_full          (fq_full),
        .item            (front_item)
    );

    nir_fifo #(
        .T     (nir_pkg::item_t),
        .DEPTH (FRONT_DEPTH)
    ) u_front_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (fq_push),
        .din   (front_item),
        .full  (fq_full),
        .pop   (fq_pop),
        .dout  (back_item),
        .empty (fq_empty)
    );

    nir_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid & cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (~fq_empty),
        .item      (back_item),
        .in_pop    (fq_pop),
        .out_full  (oq_full),
        .out_push  (oq_push),
        .res       (back_res)
    );

    nir_fifo #(
        .T     (nir_pkg::res_t),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (oq_push),
        .din   (back_res),
        .full  (oq_full),
        .pop   (pop),
        .dout  (out_res),
        .empty (empty)
    );

    assign write_en   = out_res.write_en;
    assign write_addr = out_res.write_addr;
    assign write_len  = out_res.write_len;
    assign nack_en    = out_res.nack_en;
    assign nack_addr  = out_res.nack_addr;
    assign image_done = out_res.image_done;

    a_done_no_nack: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> !(nack_en && image_done))
        else $error("nack and done in one word");

    a_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !write_en) |-> (write_addr == '0 && write_len == '0))
        else $error("write fields not cleared");

    a_write_len: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && write_en) |-> (write_len != '0 && write_len <= nir_pkg::MAX_PAYLOAD))
        else $error("bad write length");

    a_back_stall: assert property (@(posedge clk) disable iff (!rst_n)
        oq_full |-> !fq_pop)
        else $error("back stage advanced into full result queue");

endmodule

[design/nir_fifo.sv]
module nir_fifo #(
    parameter type T     = logic,
    parameter int  DEPTH = 2
) (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  T     din,
    output logic full,
    input  logic pop,
    output T     dout,
    output logic empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    T mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic do_push;
    logic do_pop;

    assign full    = (count_reg == FULL_CNT);
    assign empty   = (count_reg == '0);
    assign do_push = push & ~full;
    assign do_pop  = pop & ~empty;
    assign dout    = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= din;
        end
    end

endmodule

[design/nir_front.sv]
module nir_front (
    input  logic                       push,
    output logic                       full,
    input  logic                       req_type,
    input  logic [nir_pkg::ID_W-1:0]   pkt_id,
    input  logic [nir_pkg::ADDR_W-1:0] pkt_addr,
    input  logic [nir_pkg::TLEN_W-1:0] pkt_total_len,
    input  logic [nir_pkg::PLEN_W-1:0] pkt_payload_len,
    output logic                       q_push,
    input  logic                       q_full,
    output nir_pkg::item_t             item
);

    assign full   = q_full;
    assign q_push = push & ~q_full;

    always_comb
    begin
        item.is_tick   = (req_type == nir_pkg::REQ_TICK);
        item.id        = pkt_id;
        item.addr      = pkt_addr;
        item.addr_zero = (pkt_addr == '0);
        item.tlen      = pkt_total_len;
        // clamp oversized payload length
        item.plen      = (pkt_payload_len > nir_pkg::MAX_PAYLOAD) ?
                         nir_pkg::MAX_PAYLOAD : pkt_payload_len;
    end

endmodule

[design/nir_back.sv]
module nir_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    input  logic [nir_pkg::TMO_W-1:0] cfg_data,
    input  logic                      in_valid,
    input  nir_pkg::item_t            item,
    output logic                      in_pop,
    input  logic                      out_full,
    output logic                      out_push,
    output nir_pkg::res_t             res
);

    nir_pkg::phase_t               phase_reg, phase_next;
    logic [nir_pkg::ID_W-1:0]      cur_id_reg, cur_id_next;
    logic [nir_pkg::EXP_W-1:0]     exp_reg, exp_next;
    logic [nir_pkg::TLEN_W-1:0]    total_reg, total_next;
    logic [nir_pkg::TMO_W-1:0]     cd_reg, cd_next;
    logic [nir_pkg::TMO_W-1:0]     tmo_reg;

    logic                          fire;
    logic                          start_new;
    logic                          stale_nack;
    logic                          start;
    logic                          start_empty;
    logic                          proc;
    logic                          tick_evt;
    logic                          tick_nack;
    logic                          hit;
    logic                          wr;
    logic                          ahead;
    logic                          finish;
    logic [nir_pkg::EXP_W-1:0]     base;
    logic [nir_pkg::EXP_W-1:0]     base_tlen;
    logic [nir_pkg::EXP_W-1:0]     addr_x;
    logic [nir_pkg::EXP_W-1:0]     exp_new;

    assign fire     = in_valid & ~out_full;
    assign in_pop   = fire;
    assign out_push = fire;

    // decode
    always_comb
    begin
        addr_x      = {1'b0, item.addr};
        start_new   = (phase_reg == nir_pkg::PH_WAIT) && !item.is_tick &&
                      (item.id > cur_id_reg);
        stale_nack  = start_new && !item.addr_zero;
        start       = start_new && item.addr_zero;
        start_empty = start && (item.tlen == '0);
        proc        = (start && !start_empty) ||
                      ((phase_reg == nir_pkg::PH_RECV) && !item.is_tick &&
                       (item.id == cur_id_reg));
        tick_evt    = (phase_reg == nir_pkg::PH_RECV) && item.is_tick;
        tick_nack   = tick_evt && (cd_reg <= nir_pkg::TMO_W'(1));
        base        = start ? '0 : exp_reg;
        base_tlen   = start ? {1'b0, item.tlen} : {1'b0, total_reg};
        hit         = proc && (addr_x == base);
        wr          = hit && (item.plen != '0);
        ahead       = proc && !hit && (addr_x > base);
        exp_new     = wr ? base + nir_pkg::EXP_W'(item.plen) : base;
        finish      = proc && !(exp_new < base_tlen);
    end

    // next state
    always_comb
    begin
        phase_next  = phase_reg;
        cur_id_next = cur_id_reg;
        exp_next    = exp_reg;
        total_next  = total_reg;
        cd_next     = cd_reg;
        if (stale_nack)
        begin
            exp_next = '0;
        end
        if (start)
        begin
            cur_id_next = item.id;
            total_next  = item.tlen;
            exp_next    = '0;
        end
        if (proc)
        begin
            exp_next = exp_new;
            if (finish)
            begin
                phase_next = nir_pkg::PH_WAIT;
            end
            else
            begin
                phase_next = nir_pkg::PH_RECV;
                cd_next    = tmo_reg;
            end
        end
        if (tick_evt)
        begin
            cd_next = tick_nack ? tmo_reg : cd_reg - 1'b1;
        end
    end

    // result
    always_comb
    begin
        res            = '0;
        res.write_en   = wr;
        res.image_done = start_empty || finish;
        if (wr)
        begin
            res.write_addr = base[nir_pkg::ADDR_W-1:0];
            res.write_len  = item.plen;
        end
        if (stale_nack)
        begin
            res.nack_en = 1'b1;
        end
        else if (ahead)
        begin
            res.nack_en   = 1'b1;
            res.nack_addr = base[nir_pkg::ADDR_W-1:0];
        end
        else if (tick_nack)
        begin
            res.nack_en   = 1'b1;
            res.nack_addr = exp_reg[nir_pkg::ADDR_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= nir_pkg::PH_WAIT;
            cur_id_reg <= '0;
            exp_reg    <= '0;
            total_reg  <= '0;
            cd_reg     <= '0;
            tmo_reg    <= nir_pkg::TMO_RESET;
        end
        else
        begin
            if (cfg_valid)
            begin
                tmo_reg <= cfg_data;
            end
            if (fire)
            begin
                phase_reg  <= phase_next;
                cur_id_reg <= cur_id_next;
                exp_reg    <= exp_next;
                total_reg  <= total_next;
                cd_reg     <= cd_next;
            end
        end
    end

endmodule

[tb/sv/nack_image_receiver_checker.sv]
module nack_image_receiver_checker
    import nir_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic              full,
    input  logic              req_type,
    input  logic [ID_W-1:0]   pkt_id,
    input  logic [ADDR_W-1:0] pkt_addr,
    input  logic [TLEN_W-1:0] pkt_total_len,
    input  logic [PLEN_W-1:0] pkt_payload_len,
    input  logic              empty,
    input  logic              pop,
    input  logic              write_en,
    input  logic [ADDR_W-1:0] write_addr,
    input  logic [PLEN_W-1:0] write_len,
    input  logic              nack_en,
    input  logic [ADDR_W-1:0] nack_addr,
    input  logic              image_done,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [TMO_W-1:0]  cfg_data,
    output int unsigned       mismatch_count,
    output int unsigned       pending
);
    timeunit 1ns;
    timeprecision 1ps;

    phase_t            rx_phase;
    logic [ID_W-1:0]   img_id;
    logic [EXP_W-1:0]  img_offset;
    logic [TLEN_W-1:0] img_len;
    logic [TMO_W-1:0]  countdown;
    logic [TMO_W-1:0]  nack_tmo;
    res_t              predicted_results[$];
    res_t              want;

    task automatic report_mismatch(input string what);
        if (mismatch_count < 100)
            $display("%0t ns: mismatch, %s", $realtime, what);
        mismatch_count++;
    endtask

    function automatic res_t advance_receiver(input logic kind, input logic [ID_W-1:0] id,
                                              input logic [ADDR_W-1:0] addr,
                                              input logic [TLEN_W-1:0] tlen,
                                              input logic [PLEN_W-1:0] plen_in);
        res_t              r;
        logic [PLEN_W-1:0] plen;
        logic              take;
        r = '0;
        take = 1'b0;
        plen = (plen_in > MAX_PAYLOAD) ? MAX_PAYLOAD : plen_in;
        if (rx_phase == PH_WAIT) begin
            if (kind != REQ_TICK && id > img_id) begin
                img_offset = '0;
                if (addr != '0) begin
                    r.nack_en = 1'b1;
                end
                else begin
                    img_id = id;
                    img_len = tlen;
                    if (tlen == '0) begin
                        r.image_done = 1'b1;
                    end
                    else begin
                        rx_phase = PH_RECV;
                        take = 1'b1;
                    end
                end
            end
        end
        else if (kind == REQ_TICK) begin
            if (countdown <= 1) begin
                r.nack_en = 1'b1;
                r.nack_addr = img_offset[ADDR_W-1:0];
                countdown = nack_tmo;
            end
            else begin
                countdown = countdown - 1'b1;
            end
        end
        else if (id == img_id) begin
            take = 1'b1;
        end

        if (take) begin
            if ({1'b0, addr} == img_offset) begin
                if (plen != '0) begin
                    r.write_en = 1'b1;
                    r.write_addr = img_offset[ADDR_W-1:0];
                    r.write_len = plen;
                    img_offset = img_offset + plen;
                end
            end
            else if ({1'b0, addr} > img_offset) begin
                r.nack_en = 1'b1;
                r.nack_addr = img_offset[ADDR_W-1:0];
            end
            if (img_offset < {1'b0, img_len}) begin
                countdown = nack_tmo;
            end
            else begin
                r.image_done = 1'b1;
                rx_phase = PH_WAIT;
            end
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            rx_phase = PH_WAIT;
            img_id = '0;
            img_offset = '0;
            img_len = '0;
            countdown = '0;
            nack_tmo = TMO_RESET;
            predicted_results.delete();
            mismatch_count = 0;
            pending = 0;
        end
        else begin
            if (cfg_valid && cfg_ready)
                nack_tmo = cfg_data;
            if (pop && !empty) begin
                if (predicted_results.size() == 0) begin
                    report_mismatch("result word with none predicted");
                end
                else begin
                    want = predicted_results.pop_front();
                    if (write_en !== want.write_en)
                        report_mismatch($sformatf("write_en got %0h expected %0h",
                                                  write_en, want.write_en));
                    if (write_addr !== want.write_addr)
                        report_mismatch($sformatf("write_addr got %0h expected %0h",
                                                  write_addr, want.write_addr));
                    if (write_len !== want.write_len)
                        report_mismatch($sformatf("write_len got %0h expected %0h",
                                                  write_len, want.write_len));
                    if (nack_en !== want.nack_en)
                        report_mismatch($sformatf("nack_en got %0h expected %0h",
                                                  nack_en, want.nack_en));
                    if (nack_addr !== want.nack_addr)
                        report_mismatch($sformatf("nack_addr got %0h expected %0h",
                                                  nack_addr, want.nack_addr));
                    if (image_done !== want.image_done)
                        report_mismatch($sformatf("image_done got %0h expected %0h",
                                                  image_done, want.image_done));
                end
            end
            if (push && !full)
                predicted_results.push_back(advance_receiver(req_type, pkt_id, pkt_addr,
                                                             pkt_total_len, pkt_payload_len));
            pending = predicted_results.size();
        end
    end

endmodule

[tb/sv/nack_image_receiver_tb.sv]
module nack_image_receiver_tb;
    import nir_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic        REQ_DATA       = ~REQ_TICK;
    localparam int unsigned RX_HOLD_CYCLES = 300;

    logic              clk;
    logic              rst_n;
    logic              push;
    logic              full;
    logic              req_type;
    logic [ID_W-1:0]   pkt_id;
    logic [ADDR_W-1:0] pkt_addr;
    logic [TLEN_W-1:0] pkt_total_len;
    logic [PLEN_W-1:0] pkt_payload_len;
    logic              empty;
    logic              pop;
    logic              write_en;
    logic [ADDR_W-1:0] write_addr;
    logic [PLEN_W-1:0] write_len;
    logic              nack_en;
    logic [ADDR_W-1:0] nack_addr;
    logic              image_done;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [TMO_W-1:0]  cfg_data;

    int unsigned       mismatch_count;
    int unsigned       pending;
    int unsigned       sent_words;
    int unsigned       tx_idle_pct;
    int unsigned       rx_idle_pct;
    logic              rx_hold_req;
    logic [ID_W-1:0]   last_id;

    nack_image_receiver u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .req_type        (req_type),
        .pkt_id          (pkt_id),
        .pkt_addr        (pkt_addr),
        .pkt_total_len   (pkt_total_len),
        .pkt_payload_len (pkt_payload_len),
        .empty           (empty),
        .pop             (pop),
        .write_en        (write_en),
        .write_addr      (write_addr),
        .write_len       (write_len),
        .nack_en         (nack_en),
        .nack_addr       (nack_addr),
        .image_done      (image_done),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data)
    );

    nack_image_receiver_checker u_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .req_type        (req_type),
        .pkt_id          (pkt_id),
        .pkt_addr        (pkt_addr),
        .pkt_total_len   (pkt_total_len),
        .pkt_payload_len (pkt_payload_len),
        .empty           (empty),
        .pop             (pop),
        .write_en        (write_en),
        .write_addr      (write_addr),
        .write_len       (write_len),
        .nack_en         (nack_en),
        .nack_addr       (nack_addr),
        .image_done      (image_done),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .mismatch_count  (mismatch_count),
        .pending         (pending)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    initial
    begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // receiver side: random pop, plus one long hold-off on request
    initial
    begin
        int unsigned held;
        held = 0;
        pop = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold_req && held < RX_HOLD_CYCLES)
            begin
                pop <= 1'b0;
                held++;
            end
            else
            begin
                pop <= ($urandom_range(99) >= rx_idle_pct);
                if (!rx_hold_req)
                    held = 0;
            end
        end
    end

    // called at a falling edge, returns at a falling edge with push still high
    task automatic send_word(input logic kind, input logic [ID_W-1:0] id,
                             input logic [ADDR_W-1:0] addr, input logic [TLEN_W-1:0] tlen,
                             input logic [PLEN_W-1:0] plen);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push <= 1'b1;
        req_type <= kind;
        pkt_id <= id;
        pkt_addr <= addr;
        pkt_total_len <= tlen;
        pkt_payload_len <= plen;
        @(posedge clk);
        while (full)
            @(posedge clk);
        sent_words++;
        @(negedge clk);
    endtask

    task automatic send_tick();
        send_word(REQ_TICK, ID_W'($urandom_range(65535)), ADDR_W'($urandom_range(65535)),
                  TLEN_W'($urandom_range(65535)), PLEN_W'($urandom_range(63)));
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic write_timeout(input logic [TMO_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // one image transfer, mostly in order, with ticks, repeats, gaps and strays
    task automatic run_transfer(input bit top_id);
        logic [ID_W-1:0]   id;
        logic [ID_W-1:0]   stray_id;
        logic [TLEN_W-1:0] tlen;
        logic [PLEN_W-1:0] plen;
        int unsigned       off;
        int unsigned       steps;
        int unsigned       pick;
        int unsigned       ahead;
        if (top_id)
            id = 16'hFFFF;
        else if (last_id > 60000)
            id = (last_id < 16'hFFFE) ? last_id + 1'b1 : 16'hFFFE;
        else
            id = last_id + ID_W'($urandom_range(1, 1000));
        last_id = id;
        case ($urandom_range(9))
            0: tlen = '0;
            1: tlen = TLEN_W'($urandom_range(161, 600));
            default: tlen = TLEN_W'($urandom_range(1, 160));
        endcase
        if ($urandom_range(5) == 0)
            send_word(REQ_DATA, id, ADDR_W'($urandom_range(1, 65535)),
                      TLEN_W'($urandom_range(65535)), PLEN_W'($urandom_range(63)));
        plen = ($urandom_range(9) == 0) ? 6'd0 : PLEN_W'($urandom_range(1, 32));
        send_word(REQ_DATA, id, '0, tlen, plen);
        off = 32'(plen);
        steps = 0;
        while (off < tlen && steps < 400)
        begin
            pick = $urandom_range(99);
            if (pick < 58)
            begin
                plen = ($urandom_range(9) == 0) ? PLEN_W'($urandom_range(33, 63)) :
                                                  PLEN_W'($urandom_range(1, 32));
                send_word(REQ_DATA, id, ADDR_W'(off), tlen, plen);
                off += (plen > MAX_PAYLOAD) ? MAX_PAYLOAD : plen;
            end
            else if (pick < 70)
                send_tick();
            else if (pick < 78 && off > 0)
                send_word(REQ_DATA, id, ADDR_W'($urandom_range(0, off - 1)), tlen,
                          PLEN_W'($urandom_range(63)));
            else if (pick < 86)
            begin
                ahead = off + $urandom_range(1, 300);
                send_word(REQ_DATA, id, (ahead > 65535) ? 16'hFFFF : ADDR_W'(ahead), tlen,
                          PLEN_W'($urandom_range(63)));
            end
            else if (pick < 92)
            begin
                stray_id = ID_W'($urandom_range(65535));
                if (stray_id == id)
                    stray_id = ~id;
                send_word(REQ_DATA, stray_id, ADDR_W'(off), tlen, PLEN_W'($urandom_range(1, 32)));
            end
            else if (pick < 96)
                send_word(REQ_DATA, id, ADDR_W'(off), tlen, '0);
            else
                send_word(1'($urandom_range(1)), ID_W'($urandom_range(65535)),
                          ADDR_W'($urandom_range(65535)), TLEN_W'($urandom_range(65535)),
                          PLEN_W'($urandom_range(63)));
            steps++;
        end
    endtask

    task automatic run_phase(input int unsigned tx_pct, input int unsigned rx_pct,
                             input int unsigned words, input logic [TMO_W-1:0] tmo,
                             input bit hold);
        int unsigned start;
        wait_drained();
        write_timeout(tmo);
        tx_idle_pct = tx_pct;
        rx_idle_pct <= rx_pct;
        rx_hold_req <= hold;
        start = sent_words;
        while (sent_words - start < words)
        begin
            repeat ($urandom_range(0, 2))
            begin
                if ($urandom_range(1))
                    send_tick();
                else
                    send_word(REQ_DATA, ID_W'($urandom_range(0, last_id)),
                              ADDR_W'($urandom_range(65535)), TLEN_W'($urandom_range(65535)),
                              PLEN_W'($urandom_range(63)));
            end
            run_transfer(1'b0);
        end
        rx_hold_req <= 1'b0;
    endtask

    initial
    begin
        int unsigned waited;
        rst_n = 1'b0;
        push = 1'b0;
        req_type = REQ_DATA;
        pkt_id = '0;
        pkt_addr = '0;
        pkt_total_len = '0;
        pkt_payload_len = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        rx_hold_req = 1'b0;
        sent_words = 0;
        last_id = '0;
        tx_idle_pct = 8;
        rx_idle_pct = 66;
        repeat (9)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed, reset timeout
        send_tick();
        send_word(REQ_DATA, 16'd0, 16'd0, 16'd50, 6'd8);
        send_word(REQ_DATA, 16'd5, 16'd100, 16'd50, 6'd8);
        send_word(REQ_DATA, 16'd5, 16'd0, 16'd0, 6'd8);
        send_word(REQ_DATA, 16'd5, 16'd0, 16'd10, 6'd8);
        send_word(REQ_DATA, 16'd6, 16'd0, 16'd100, 6'd63);
        send_word(REQ_DATA, 16'd6, 16'd32, 16'd100, 6'd0);
        send_word(REQ_DATA, 16'd6, 16'd0, 16'd100, 6'd8);
        send_word(REQ_DATA, 16'd6, 16'hFFFF, 16'd100, 6'd32);
        send_word(REQ_DATA, 16'd7, 16'd32, 16'd100, 6'd4);
        send_tick();
        send_word(REQ_DATA, 16'd6, 16'd32, 16'd100, 6'd32);
        send_word(REQ_DATA, 16'd6, 16'd64, 16'd100, 6'd36);
        send_word(REQ_DATA, 16'd6, 16'd96, 16'd100, 6'd4);

        // directed, short timeout
        wait_drained();
        write_timeout(12'd2);
        send_word(REQ_DATA, 16'd9, 16'hFFFF, 16'hFFFF, 6'd32);
        send_word(REQ_DATA, 16'd9, 16'd0, 16'd40, 6'd16);
        repeat (3)
            send_tick();
        send_word(REQ_DATA, 16'd9, 16'd16, 16'd40, 6'd24);
        send_tick();
        last_id = 16'd9;

        run_phase(8, 66, 130, 12'd0, 1'b0);
        run_phase(66, 8, 60, 12'd1, 1'b0);
        run_phase(66, 8, 60, 12'hFFF, 1'b0);
        run_phase(0, 0, 40, 12'd7, 1'b1);
        run_phase(0, 0, 120, TMO_W'($urandom_range(3, 12)), 1'b0);
        run_transfer(1'b1);

        push <= 1'b0;
        @(negedge clk);
        waited = 0;
        while (pending != 0 && waited < 20000)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (16)
            @(negedge clk);
        if (mismatch_count == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
